>>> hdl/bscl_pkg.sv
// shared types, constants and helpers of the bounded sorted candidate list
package bscl_pkg;

   // list geometry
   localparam int LIST_DEPTH = 64;
   localparam int PICK_MAX   = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH + 1);
   localparam int PICK_W     = $clog2(PICK_MAX + 1);
   localparam int ID_W       = 32;
   localparam int DIST_W     = 32;

   // configuration register widths and channel widths
   localparam int CAP_W        = 7;
   localparam int MAXP_W       = 5;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_IDX_W    = 1;
   localparam int REQ_TDATA_W  = 72;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 48;
   localparam int RSP_TUSER_W  = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PICK = 1'd1;

   // request kinds
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_PICK   = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_DEC,
      S_INS,
      S_PICK,
      S_PFIN,
      S_ONE
   } state_type;

   // controls shared by the whole row of cells
   typedef struct packed {
      logic             cmp;
      logic             ins;
      logic             clear;
      logic             mark;
      logic [IDX_W-1:0] loc;
      logic [IDX_W-1:0] last_pos;
      logic [IDX_W-1:0] count;
      logic [IDX_W-1:0] ptr;
   } chain_ctrl_type;

   // controls of one cell
   typedef struct packed {
      logic valid;
      logic cmp;
      logic load;
      logic shift;
      logic clear;
      logic mark;
   } cell_ctrl_type;

   // capacity in effect: zero acts as one, large values clip to the depth
   function automatic logic [IDX_W-1:0] eff_capacity(input logic [CAP_W-1:0] raw);
      logic [IDX_W-1:0] res;
      if (raw == '0) begin
         res = IDX_W'(1);
      end else if (IDX_W'(raw) > IDX_W'(LIST_DEPTH)) begin
         res = IDX_W'(LIST_DEPTH);
      end else begin
         res = IDX_W'(raw);
      end
      return res;
   endfunction

   // pick limit in effect: zero acts as one, large values clip to the max
   function automatic logic [PICK_W-1:0] eff_pick(input logic [MAXP_W-1:0] raw);
      logic [PICK_W-1:0] res;
      if (raw == '0) begin
         res = PICK_W'(1);
      end else if (PICK_W'(raw) > PICK_W'(PICK_MAX)) begin
         res = PICK_W'(PICK_MAX);
      end else begin
         res = PICK_W'(raw);
      end
      return res;
   endfunction

endpackage

>>> hdl/bscl_cell.sv
// one list slot: stored entry, compare against the candidate, shift from the left
module bscl_cell
   import bscl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [ID_W-1:0]          cand_id,
   input  logic signed [DIST_W-1:0] cand_dist,
   input  logic [ID_W-1:0]          left_id,
   input  logic signed [DIST_W-1:0] left_dist,
   input  logic                     left_chk,
   output logic [ID_W-1:0]          ent_id,
   output logic signed [DIST_W-1:0] ent_dist,
   output logic                     ent_chk,
   output logic                     lt,
   output logic                     eq
);

   logic [ID_W-1:0]          id_ff;
   logic signed [DIST_W-1:0] dist_ff;
   logic                     chk_ff;
   logic                     lt_ff;
   logic                     eq_ff;
   logic                     before_in;
   logic                     same_id_in;

   // entry sorts strictly before the candidate
   always_comb begin
      if (dist_ff != cand_dist) begin
         before_in = dist_ff < cand_dist;
      end else begin
         before_in = id_ff < cand_id;
      end
      same_id_in = id_ff == cand_id;
   end

   // compare flags, gated by slot occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctrl.cmp) begin
         lt_ff <= ctrl.valid & before_in;
         eq_ff <= ctrl.valid & same_id_in;
      end
   end

   // entry payload: load candidate or take the left neighbor's entry
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         id_ff   <= cand_id;
         dist_ff <= cand_dist;
      end else if (ctrl.shift) begin
         id_ff   <= left_id;
         dist_ff <= left_dist;
      end
   end

   // checked mark
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
      end else if (ctrl.clear || ctrl.load) begin
         chk_ff <= 1'b0;
      end else if (ctrl.shift) begin
         chk_ff <= left_chk;
      end else if (ctrl.mark) begin
         chk_ff <= 1'b1;
      end
   end

   assign ent_id   = id_ff;
   assign ent_dist = dist_ff;
   assign ent_chk  = chk_ff;
   assign lt       = lt_ff;
   assign eq       = eq_ff;

endmodule

>>> hdl/bscl_chain.sv
// row of list cells with insert-position encode, duplicate check and pick read
module bscl_chain
   import bscl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  chain_ctrl_type           ctrl,
   input  logic [ID_W-1:0]          cand_id,
   input  logic signed [DIST_W-1:0] cand_dist,
   output logic [IDX_W-1:0]         loc,
   output logic                     dup,
   output logic [ID_W-1:0]          rd_id,
   output logic                     rd_chk
);

   logic [ID_W-1:0]          id_q   [LIST_DEPTH];
   logic signed [DIST_W-1:0] dist_q [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]    chk_q;
   logic [LIST_DEPTH-1:0]    lt_q;
   logic [LIST_DEPTH-1:0]    eq_q;
   logic [LIST_DEPTH-1:0]    at_q;
   logic [LIST_DEPTH-1:0]    sel_q;

   genvar g;
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
         cell_ctrl_type            cc;
         logic [ID_W-1:0]          l_id;
         logic signed [DIST_W-1:0] l_dist;
         logic                     l_chk;

         // per-slot enables from the slot's own index
         always_comb begin
            cc.valid = IDX_W'(g) < ctrl.count;
            cc.cmp   = ctrl.cmp;
            cc.load  = ctrl.ins && (IDX_W'(g) == ctrl.loc);
            cc.shift = ctrl.ins && (IDX_W'(g) > ctrl.loc) && (IDX_W'(g) <= ctrl.last_pos);
            cc.clear = ctrl.clear;
            cc.mark  = ctrl.mark && (IDX_W'(g) == ctrl.ptr);
         end

         // left neighbor, the head slot never shifts
         if (g == 0) begin : g_head
            assign l_id   = '0;
            assign l_dist = '0;
            assign l_chk  = 1'b0;
            assign at_q[g] = ~lt_q[g];
         end else begin : g_body
            assign l_id   = id_q[g-1];
            assign l_dist = dist_q[g-1];
            assign l_chk  = chk_q[g-1];
            assign at_q[g] = ~lt_q[g] & lt_q[g-1];
         end

         assign sel_q[g] = IDX_W'(g) == ctrl.ptr;

         bscl_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cc),
            .cand_id   (cand_id),
            .cand_dist (cand_dist),
            .left_id   (l_id),
            .left_dist (l_dist),
            .left_chk  (l_chk),
            .ent_id    (id_q[g]),
            .ent_dist  (dist_q[g]),
            .ent_chk   (chk_q[g]),
            .lt        (lt_q[g]),
            .eq        (eq_q[g])
         );
      end
   endgenerate

   // boundary is one-hot, so the position is an or of slot indexes
   always_comb begin
      loc = '0;
      dup = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         loc = loc | (at_q[i] ? IDX_W'(i) : IDX_W'(0));
         dup = dup | (at_q[i] & eq_q[i]);
      end
      if (lt_q[LIST_DEPTH-1]) begin
         loc = IDX_W'(LIST_DEPTH);
      end
   end

   // pick read at the scan pointer
   always_comb begin
      rd_id  = '0;
      rd_chk = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         rd_id  = rd_id | (sel_q[i] ? id_q[i] : '0);
         rd_chk = rd_chk | (sel_q[i] & chk_q[i]);
      end
   end

endmodule

>>> hdl/bounded_sorted_candidate_list_top.sv
// top level of the bounded sorted candidate list
//
// Usage: requests enter on req_* (tuser = action, tdata = id, distance,
// pick start index); results leave on rsp_* with tlast on the final result
// of each request. Configuration is written on csr_* while the block is idle.
// Steps of each request after it is accepted:
//   insert : compare, encode, shift/commit, then the one result; the row
//            compares all slots at once
//   pick   : one scanned slot per cycle while the output register is free,
//            from start_index until the fill count or the pick limit is reached;
//            results stream out one per found entry, the last one held until
//            the scan ends
//   clear and unused actions : a single result
// One request is worked on at a time; req_tready is high only while idle.
// A finished result sits in the output register while the next request is
// taken. When the receiver stalls, every result step and every pick scan
// step waits until rsp_tready frees the output register.
// Reset empties the list, clears all checked marks, sets capacity to 64
// and the pick limit to 1; entry ids and distances are not cleared.
module bounded_sorted_candidate_list_top
   import bscl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // cand_id, cand_dist, start_index, pad
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // action
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // position, entry_id, fill_count, pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // rejected, found
   output logic                   rsp_tlast,
   // configuration port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [ID_W-1:0]          cand_id_ff;
   logic signed [DIST_W-1:0] cand_dist_ff;
   logic [IDX_W-1:0]         ptr_ff;
   logic [IDX_W-1:0]         count_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [MAXP_W-1:0]        pick_ff;
   logic [IDX_W-1:0]         loc_ff;
   logic                     dup_ff;
   logic [PICK_W-1:0]        k_ff;
   logic                     pend_ff;
   logic [IDX_W-1:0]         pend_pos_ff;
   logic [ID_W-1:0]          pend_id_ff;

   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_pos_ff;
   logic                     rsp_rej_ff;
   logic                     rsp_fnd_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic [IDX_W-1:0]         rsp_fill_ff;
   logic                     rsp_last_ff;

   action_type               req_action;
   logic                     accept;
   logic                     out_free;
   logic [IDX_W-1:0]         cap_eff;
   logic [IDX_W-1:0]         cap_new;
   logic [PICK_W-1:0]        pick_eff;
   logic [IDX_W-1:0]         chain_loc;
   logic                     chain_dup;
   logic [ID_W-1:0]          rd_id;
   logic                     rd_chk;

   // insert decision
   logic                     ins_rej;
   logic [IDX_W-1:0]         ins_last;

   // pick scan step
   logic                     pick_end;
   logic                     pick_hit;

   // control outputs
   chain_ctrl_type           cctl;
   logic                     emit;
   logic [IDX_W-1:0]         emit_pos;
   logic                     emit_rej;
   logic                     emit_fnd;
   logic [ID_W-1:0]          emit_id;
   logic [IDX_W-1:0]         emit_fill;
   logic                     emit_last;
   logic                     do_ins;
   logic                     do_pick;
   logic                     do_clear;

   assign req_action = action_type'(req_tuser);
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign cap_eff    = eff_capacity(cap_ff);
   assign cap_new    = eff_capacity(csr_wdata[CAP_W-1:0]);
   assign pick_eff   = eff_pick(pick_ff);

   // insert: reject duplicates and candidates past the end of a full list
   always_comb begin
      ins_rej  = 1'b0;
      ins_last = count_ff;
      if (loc_ff < count_ff) begin
         if (dup_ff) begin
            ins_rej = 1'b1;
         end else if (count_ff >= cap_eff) begin
            ins_last = cap_eff - IDX_W'(1);
         end
      end else if (count_ff >= cap_eff) begin
         ins_rej = 1'b1;
      end
   end

   // pick: stop at the fill count or at the limit
   assign pick_end = (ptr_ff >= count_ff) || (k_ff == pick_eff);
   assign pick_hit = ~pick_end & ~rd_chk;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_INSERT: state_in = S_CMP;
                  ACT_PICK:   state_in = S_PICK;
                  ACT_CLEAR:  state_in = S_ONE;
                  ACT_NONE:   state_in = S_ONE;
                  default:    state_in = S_ONE;
               endcase
            end
         end
         S_CMP: state_in = S_DEC;
         S_DEC: state_in = S_INS;
         S_INS: begin
            if (out_free) state_in = S_IDLE;
         end
         S_PICK: begin
            if (out_free && pick_end) state_in = S_PFIN;
         end
         S_PFIN: begin
            if (out_free) state_in = S_IDLE;
         end
         S_ONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      do_ins    = 1'b0;
      do_pick   = 1'b0;
      do_clear  = accept && (req_action == ACT_CLEAR);
      emit      = 1'b0;
      emit_pos  = '0;
      emit_rej  = 1'b0;
      emit_fnd  = 1'b0;
      emit_id   = '0;
      emit_fill = count_ff;
      emit_last = 1'b1;
      unique case (state_ff)
         S_INS: begin
            if (out_free) begin
               emit     = 1'b1;
               do_ins   = ~ins_rej;
               emit_rej = ins_rej;
               if (ins_rej) begin
                  emit_pos = cap_eff;
               end else begin
                  emit_pos  = loc_ff;
                  emit_fill = ins_last + IDX_W'(1);
               end
            end
         end
         S_PICK: begin
            if (out_free && pick_hit) begin
               do_pick   = 1'b1;
               emit      = pend_ff;
               emit_pos  = pend_pos_ff;
               emit_fnd  = 1'b1;
               emit_id   = pend_id_ff;
               emit_last = 1'b0;
            end
         end
         S_PFIN: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_ff) begin
                  emit_pos = pend_pos_ff;
                  emit_fnd = 1'b1;
                  emit_id  = pend_id_ff;
               end else begin
                  emit_pos = count_ff;
               end
            end
         end
         S_ONE: begin
            emit = out_free;
         end
         S_IDLE, S_CMP, S_DEC: begin
            emit = 1'b0;
         end
         default: emit = 1'b0;
      endcase
   end

   // row controls
   always_comb begin
      cctl.cmp      = state_ff == S_CMP;
      cctl.ins      = do_ins;
      cctl.clear    = do_clear;
      cctl.mark     = do_pick;
      cctl.loc      = loc_ff;
      cctl.last_pos = ins_last;
      cctl.count    = count_ff;
      cctl.ptr      = ptr_ff;
   end

   bscl_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cctl),
      .cand_id   (cand_id_ff),
      .cand_dist (cand_dist_ff),
      .loc       (chain_loc),
      .dup       (chain_dup),
      .rd_id     (rd_id),
      .rd_chk    (rd_chk)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_W'(LIST_DEPTH);
         pick_ff  <= MAXP_W'(1);
         count_ff <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_CAPACITY)) begin
            cap_ff <= csr_wdata[CAP_W-1:0];
            if (count_ff > cap_new) count_ff <= cap_new;
         end
         if (csr_we && (csr_index == CSR_MAX_PICK)) begin
            pick_ff <= csr_wdata[MAXP_W-1:0];
         end
         if (do_clear) begin
            count_ff <= '0;
         end else if (do_ins) begin
            count_ff <= ins_last + IDX_W'(1);
         end
      end
   end

   // request payload and insert position
   always_ff @(posedge clock) begin
      if (accept) begin
         cand_id_ff   <= req_tdata[ID_W-1:0];
         cand_dist_ff <= req_tdata[ID_W+DIST_W-1:ID_W];
      end
      if (state_ff == S_DEC) begin
         loc_ff <= chain_loc;
         dup_ff <= chain_dup;
      end
   end

   // pick scan pointer, found count and held result
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         k_ff    <= '0;
         pend_ff <= 1'b0;
      end else if (accept) begin
         ptr_ff  <= req_tdata[ID_W+DIST_W+IDX_W-1:ID_W+DIST_W];
         k_ff    <= '0;
         pend_ff <= 1'b0;
      end else if ((state_ff == S_PICK) && out_free && !pick_end) begin
         ptr_ff <= ptr_ff + IDX_W'(1);
         if (pick_hit) begin
            k_ff    <= k_ff + PICK_W'(1);
            pend_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pick) begin
         pend_pos_ff <= ptr_ff;
         pend_id_ff  <= rd_id;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_pos_ff  <= emit_pos;
         rsp_rej_ff  <= emit_rej;
         rsp_fnd_ff  <= emit_fnd;
         rsp_id_ff   <= emit_id;
         rsp_fill_ff <= emit_fill;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_fill_ff, rsp_id_ff, rsp_pos_ff};
   assign rsp_tuser  = {rsp_fnd_ff, rsp_rej_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/bscl_checker.sv
// port-level checks of the candidate list and their binding to the top level
module bscl_checker
   import bscl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic                   rsp_tlast
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a result is never both rejected and found
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result both rejected and found");

   // a rejected insert is always the only result of its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("rejected result without last");

   // the fill count never passes the list depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[45:39] <= 7'(LIST_DEPTH))
      else $error("fill count beyond depth");

   // results without a found entry carry a zero id
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[38:7] == '0)
      else $error("nonzero id on result without entry");

endmodule

bind bounded_sorted_candidate_list_top bscl_checker u_bscl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
